// ===== rtl/segment_pair_closest_points_defines.svh =====
// Assertion macros used by the queue RTL
`ifndef SEGMENT_PAIR_CLOSEST_POINTS_DEFINES_SVH
`define SEGMENT_PAIR_CLOSEST_POINTS_DEFINES_SVH

// Implication checked on every clock, masked during reset
`define SPCP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset
`define SPCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/spcp_pkg.sv =====
package spcp_pkg;
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int DOT_BITS   = 2 * DIFF_BITS + 2;
   localparam int PROD_BITS  = 2 * DOT_BITS + 1;
   localparam int NUM_BITS   = PROD_BITS + 1;
   localparam int Q_BITS     = FRAC_BITS + 1;
   localparam int PT_BITS    = 32;
   localparam int REQ_BYTES  = (12 * COORD_BITS + 7) / 8;
   localparam int RSP_BITS   = 6 * PT_BITS + 2 * Q_BITS;
   localparam int RSP_BYTES  = (RSP_BITS + 7) / 8;
   localparam int NUM_DIV    = 2;
   localparam int DIV_STAGES = FRAC_BITS;
   localparam int QDEPTH     = 4;
   localparam int QIDX_BITS  = 2;
   localparam int QCNT_BITS  = 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [DOT_BITS-1:0]   dot_type;
   typedef logic signed [NUM_BITS-1:0]   num_type;
   typedef logic [Q_BITS-1:0]            q_type;

   // Division job: num/den as Q0.FRAC fraction, already screened for ends
   typedef struct packed {
      logic    force_zero;
      logic    force_one;
      num_type num;
      num_type den;
   } div_job_type;

   // Item passed from front to back through the queue
   typedef struct packed {
      coord_type [2:0] s1;
      coord_type [2:0] s2;
      diff_type  [2:0] u;
      diff_type  [2:0] v;
      div_job_type     js;
      div_job_type     jt;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;
endpackage

// ===== rtl/spcp_front.sv =====
// Front: differences, dot products, products and case selection (4 stages)
module spcp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  spcp_pkg::coord_type [11:0] in_p,
   output logic                     out_valid,
   output spcp_pkg::work_type       out_work
);
   import spcp_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;

   // stage 1: differences
   coord_type [2:0] s1a_ff, s2a_ff;
   diff_type  [2:0] u1_ff, v1d_ff, w1_ff;
   // stage 2: dots
   coord_type [2:0] s1b_ff, s2b_ff;
   diff_type  [2:0] u2_ff, v2d_ff;
   dot_type a2_ff, b2_ff, c2_ff, d2_ff, e2_ff;
   // stage 3: products
   coord_type [2:0] s1c_ff, s2c_ff;
   diff_type  [2:0] u3_ff, v3d_ff;
   dot_type a3_ff, b3_ff, c3_ff, d3_ff, e3_ff;
   num_type ac_ff, bb_ff, be_ff, cd_ff, ae_ff, bd_ff;
   // stage 4: result
   work_type w4_ff;

   always_comb begin
      v1_in = adv ? in_valid : v1_ff;
      v2_in = adv ? v1_ff : v2_ff;
      v3_in = adv ? v2_ff : v3_ff;
      v4_in = adv ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in; v2_ff <= v2_in; v3_ff <= v3_in; v4_ff <= v4_in;
      end
   end

   // case selection on stage 3 registers
   function automatic div_job_type mkjob(input num_type n, input num_type d);
      div_job_type j;
      j.num = n;
      j.den = d;
      j.force_zero = (d <= 0) || (n <= 0);
      j.force_one  = !j.force_zero && (n >= d);
      return j;
   endfunction

   function automatic num_type wx(input dot_type x);
      return num_type'(x);
   endfunction

   div_job_type js_c, jt_c;
   always_comb begin
      num_type dd, sn, sd, tn, td, nm;
      dd = ac_ff - bb_ff;
      nm = '0;
      sn = '0; sd = num_type'(1); tn = '0; td = num_type'(1);
      js_c = mkjob('0, num_type'(1));
      jt_c = mkjob('0, num_type'(1));
      if (a3_ff == 0 && c3_ff == 0) begin
         js_c = mkjob('0, num_type'(1));
         jt_c = mkjob('0, num_type'(1));
      end else if (a3_ff == 0) begin
         jt_c = mkjob(wx(e3_ff), wx(c3_ff));
      end else if (c3_ff == 0) begin
         js_c = mkjob(-wx(d3_ff), wx(a3_ff));
      end else begin
         if (dd == 0) begin
            sn = '0; sd = num_type'(1); tn = wx(e3_ff); td = wx(c3_ff);
         end else begin
            sn = be_ff - cd_ff;
            tn = ae_ff - bd_ff;
            sd = dd; td = dd;
            if (sn < 0) begin
               sn = '0; tn = wx(e3_ff); td = wx(c3_ff);
            end else if (sn > sd) begin
               sn = sd; tn = wx(e3_ff) + wx(b3_ff); td = wx(c3_ff);
            end
         end
         if (tn < 0 || tn > td) begin
            nm = -wx(d3_ff);
            if (tn < 0) begin
               tn = '0;
            end else begin
               tn = td;
               nm = -wx(d3_ff) + wx(b3_ff);
            end
            if (nm < 0) begin
               sn = '0;
            end else if (nm > wx(a3_ff)) begin
               sn = sd;
            end else begin
               sn = nm; sd = wx(a3_ff);
            end
         end
         js_c = mkjob(sn, sd);
         jt_c = mkjob(tn, td);
      end
   end

   // operands widened first so each product keeps all its bits
   function automatic dot_type dot3(input diff_type [2:0] p, input diff_type [2:0] q);
      return dot_type'(p[0]) * dot_type'(q[0]) + dot_type'(p[1]) * dot_type'(q[1])
           + dot_type'(p[2]) * dot_type'(q[2]);
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s1a_ff[i] <= in_p[i];
            s2a_ff[i] <= in_p[6+i];
            u1_ff[i]  <= diff_type'(in_p[3+i]) - diff_type'(in_p[i]);
            v1d_ff[i] <= diff_type'(in_p[9+i]) - diff_type'(in_p[6+i]);
            w1_ff[i]  <= diff_type'(in_p[i]) - diff_type'(in_p[6+i]);
         end
         s1b_ff <= s1a_ff; s2b_ff <= s2a_ff; u2_ff <= u1_ff; v2d_ff <= v1d_ff;
         a2_ff <= dot3(u1_ff, u1_ff);
         b2_ff <= dot3(u1_ff, v1d_ff);
         c2_ff <= dot3(v1d_ff, v1d_ff);
         d2_ff <= dot3(u1_ff, w1_ff);
         e2_ff <= dot3(v1d_ff, w1_ff);
         s1c_ff <= s1b_ff; s2c_ff <= s2b_ff; u3_ff <= u2_ff; v3d_ff <= v2d_ff;
         a3_ff <= a2_ff; b3_ff <= b2_ff; c3_ff <= c2_ff; d3_ff <= d2_ff; e3_ff <= e2_ff;
         ac_ff <= wx(a2_ff) * wx(c2_ff);
         bb_ff <= wx(b2_ff) * wx(b2_ff);
         be_ff <= wx(b2_ff) * wx(e2_ff);
         cd_ff <= wx(c2_ff) * wx(d2_ff);
         ae_ff <= wx(a2_ff) * wx(e2_ff);
         bd_ff <= wx(b2_ff) * wx(d2_ff);
         w4_ff.s1 <= s1c_ff;
         w4_ff.s2 <= s2c_ff;
         w4_ff.u  <= u3_ff;
         w4_ff.v  <= v3d_ff;
         w4_ff.js <= js_c;
         w4_ff.jt <= jt_c;
      end
   end

   assign out_valid = v4_ff;
   assign out_work  = w4_ff;
endmodule

// ===== rtl/spcp_queue.sv =====
// Short FIFO between front and back
module spcp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  spcp_pkg::work_type   push_data,
   input  logic                 pop,
   output spcp_pkg::work_type   pop_data,
   output spcp_pkg::qstat_type  stat,
   output logic [spcp_pkg::QCNT_BITS-1:0] count
);
   import spcp_pkg::*;

   work_type mem_ff [QDEPTH];
   logic [QIDX_BITS-1:0] wr_ff, rd_ff, wr_in, rd_in;
   logic [QCNT_BITS-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   assign pop_data   = mem_ff[rd_ff];
   assign stat.full  = (cnt_ff == QCNT_BITS'(QDEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign count      = cnt_ff;

`include "segment_pair_closest_points_defines.svh"
   `SPCP_ASSERT_IMP(a_no_overflow, clock, reset, stat.full, !push || pop, "queue overflow")
   `SPCP_ASSERT_IMP(a_no_underflow, clock, reset, stat.empty, !pop, "queue underflow")
   `SPCP_ASSERT_NEXT(a_cnt_track, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1,
      "queue count mismatch")
endmodule

// ===== rtl/spcp_back.sv =====
// Back: pipelined restoring dividers for s and t, then point formation
module spcp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  spcp_pkg::work_type   in_work,
   output logic                 out_valid,
   output logic [spcp_pkg::RSP_BITS-1:0] out_data
);
   import spcp_pkg::*;

   localparam int NS = DIV_STAGES + 2;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   coord_type [DIV_STAGES:0][2:0] s1_ff, s2_ff;
   diff_type  [DIV_STAGES:0][2:0] u_ff, v_ff;
   num_type   [DIV_STAGES:0][NUM_DIV-1:0] rem_ff, den_ff;
   q_type     [DIV_STAGES:0][NUM_DIV-1:0] q_ff;
   logic      [DIV_STAGES:0][NUM_DIV-1:0] one_ff, zero_ff;
   logic [RSP_BITS-1:0] res_ff;

   always_comb begin
      vld_in = adv ? {vld_ff[NS-2:0], in_valid} : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= vld_in;
   end

   // one quotient bit per stage and per divider
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff[0] <= in_work.s1; s2_ff[0] <= in_work.s2;
         u_ff[0]  <= in_work.u;  v_ff[0]  <= in_work.v;
         rem_ff[0][0] <= in_work.js.num; den_ff[0][0] <= in_work.js.den;
         one_ff[0][0] <= in_work.js.force_one; zero_ff[0][0] <= in_work.js.force_zero;
         rem_ff[0][1] <= in_work.jt.num; den_ff[0][1] <= in_work.jt.den;
         one_ff[0][1] <= in_work.jt.force_one; zero_ff[0][1] <= in_work.jt.force_zero;
         q_ff[0] <= '0;
         for (int k = 0; k < DIV_STAGES; k++) begin
            s1_ff[k+1] <= s1_ff[k]; s2_ff[k+1] <= s2_ff[k];
            u_ff[k+1] <= u_ff[k]; v_ff[k+1] <= v_ff[k];
            den_ff[k+1] <= den_ff[k]; one_ff[k+1] <= one_ff[k]; zero_ff[k+1] <= zero_ff[k];
            for (int j = 0; j < NUM_DIV; j++) begin
               if ((rem_ff[k][j] <<< 1) >= den_ff[k][j]) begin
                  rem_ff[k+1][j] <= (rem_ff[k][j] <<< 1) - den_ff[k][j];
                  q_ff[k+1][j]   <= {q_ff[k][j][Q_BITS-2:0], 1'b1};
               end else begin
                  rem_ff[k+1][j] <= rem_ff[k][j] <<< 1;
                  q_ff[k+1][j]   <= {q_ff[k][j][Q_BITS-2:0], 1'b0};
               end
            end
         end
      end
   end

   // final: select parameter, form points (products kept modulo 2^32)
   q_type qs, qt;
   logic [PT_BITS-1:0] pt [6];
   always_comb begin
      qs = zero_ff[DIV_STAGES][0] ? '0 :
           one_ff[DIV_STAGES][0] ? q_type'(1 << FRAC_BITS) : q_ff[DIV_STAGES][0];
      qt = zero_ff[DIV_STAGES][1] ? '0 :
           one_ff[DIV_STAGES][1] ? q_type'(1 << FRAC_BITS) : q_ff[DIV_STAGES][1];
      for (int i = 0; i < 3; i++) begin
         pt[i]   = PT_BITS'({{(PT_BITS-COORD_BITS){s1_ff[DIV_STAGES][i][COORD_BITS-1]}},
                   s1_ff[DIV_STAGES][i]} << FRAC_BITS)
                 + PT_BITS'(u_ff[DIV_STAGES][i]) * PT_BITS'(qs);
         pt[3+i] = PT_BITS'({{(PT_BITS-COORD_BITS){s2_ff[DIV_STAGES][i][COORD_BITS-1]}},
                   s2_ff[DIV_STAGES][i]} << FRAC_BITS)
                 + PT_BITS'(v_ff[DIV_STAGES][i]) * PT_BITS'(qt);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) res_ff <= {qt, qs, pt[5], pt[4], pt[3], pt[2], pt[1], pt[0]};
   end

   assign out_valid = vld_ff[NS-1];
   assign out_data  = res_ff;
endmodule

// ===== rtl/segment_pair_closest_points.sv =====
// Channel | Dir | Payload
// req     | in  | 12 x 16-bit signed coordinates, one segment pair per item
// rsp     | out | 6 x 32-bit Q16.16 points, param_s, param_t (17 bits each)
// Throughput: one item per cycle while rsp is ready. Stages: 4 front + queue + 18 back.
// The front pipeline runs while the queue has room; the back pipeline stalls only on rsp.
// The back divider is 16 pipelined restoring steps, one quotient bit each, two lanes.
// Reset is synchronous and clears valid bits, queue pointers and queue count only.
module segment_pair_closest_points (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // seg1_start_x,y,z, seg1_end_x,y,z, seg2_start_x,y,z, seg2_end_x,y,z
   input  logic [8*spcp_pkg::REQ_BYTES-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // near1_x,y,z, near2_x,y,z, param_s, param_t, zero pad
   output logic [8*spcp_pkg::RSP_BYTES-1:0] rsp_tdata
);
   import spcp_pkg::*;

   coord_type [11:0] req_p;
   logic f_valid, f_adv, b_adv, b_valid, q_pop;
   work_type f_work, q_work;
   qstat_type q_stat;
   logic [QCNT_BITS-1:0] q_cnt;
   logic [RSP_BITS-1:0] b_data;

   assign req_p = req_tdata[12*COORD_BITS-1:0];

   // front may advance when its last stage is empty or the queue takes the item
   assign f_adv      = !f_valid || (q_cnt != QCNT_BITS'(QDEPTH)) || q_pop;
   assign req_tready = f_adv;
   assign b_adv      = !rsp_tvalid || rsp_tready;
   assign q_pop      = b_adv && !q_stat.empty;

   spcp_front u_front (
      .clock(clock), .reset(reset), .adv(f_adv),
      .in_valid(req_tvalid && req_tready), .in_p(req_p),
      .out_valid(f_valid), .out_work(f_work)
   );

   spcp_queue u_queue (
      .clock(clock), .reset(reset),
      .push(f_valid && f_adv), .push_data(f_work),
      .pop(q_pop), .pop_data(q_work), .stat(q_stat), .count(q_cnt)
   );

   spcp_back u_back (
      .clock(clock), .reset(reset), .adv(b_adv),
      .in_valid(q_pop), .in_work(q_work),
      .out_valid(b_valid), .out_data(b_data)
   );

   assign rsp_tvalid = b_valid;
   assign rsp_tdata  = (8*RSP_BYTES)'(b_data);
endmodule
